// ===== rtl/mdss_pkg.sv =====
// Shared types and codes for the motor drive start/stop sequencer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package mdss_pkg;

    localparam int CFG_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // Register indexes on the config port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOOT_CHARGE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALIGN       = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STOP_DWELL  = 2'd2;

    localparam logic [CFG_WIDTH-1:0] BOOT_CHARGE_RESET = 16'd10;
    localparam logic [CFG_WIDTH-1:0] ALIGN_RESET       = 16'd500;
    localparam logic [CFG_WIDTH-1:0] STOP_DWELL_RESET  = 16'd400;

    // Phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CALIB = 3'd1;
    localparam logic [2:0] PH_BOOT  = 3'd2;
    localparam logic [2:0] PH_ALIGN = 3'd3;
    localparam logic [2:0] PH_RUN   = 3'd4;
    localparam logic [2:0] PH_STOP  = 3'd5;
    localparam logic [2:0] PH_FNOW  = 3'd6;
    localparam logic [2:0] PH_FOVER = 3'd7;

    // Command codes
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_MEASURE = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_ACK     = 3'd4;

    typedef struct packed {
        logic [2:0] command;
        logic       fault_active;
        logic       fault_occurred;
        logic       offsets_known;
        logic       calib_done;
        logic       sensor_aligned;
        logic       sensor_online;
        logic       capture_ok;
        logic       speed_ok;
        logic       timing_overrun;
    } in_word_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       pwm_on;
        logic       calib_start;
        logic       low_sides_on;
        logic       align_current;
        logic       run_entry;
        logic       speed_fault;
        logic       sensor_reset;
    } out_word_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] boot_charge_ticks;
        logic [CFG_WIDTH-1:0] align_ticks;
        logic [CFG_WIDTH-1:0] stop_dwell_ticks;
    } cfg_t;

    // Sequencer state apart from the wait counter
    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] held_command;
        logic       pwm_enabled;
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/mdss_cfg.sv =====
// Config register file for the sequencer: three tick counts.
// Depends on mdss_pkg.
`default_nettype none

module mdss_cfg
    import mdss_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       cfg_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boot_charge_ticks <= BOOT_CHARGE_RESET;
            cfg_reg.align_ticks       <= ALIGN_RESET;
            cfg_reg.stop_dwell_ticks  <= STOP_DWELL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOOT_CHARGE: cfg_reg.boot_charge_ticks <= cfg_data;
                REG_ALIGN:       cfg_reg.align_ticks       <= cfg_data;
                REG_STOP_DWELL:  cfg_reg.stop_dwell_ticks  <= cfg_data;
                default:         ; // unmapped index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/mdss_step.sv =====
// Per-tick transition logic: next state and result word from one input word.
// Depends on mdss_pkg. Purely combinational.
`default_nettype none

module mdss_step
    import mdss_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  wire in_word_t          in_word,
    input  wire cfg_t              cfg,
    input  wire seq_state_t        cur,
    input  wire logic [TIMER_BITS-1:0] wait_cur,
    output seq_state_t             nxt,
    output logic [TIMER_BITS-1:0]  wait_nxt,
    output out_word_t              res
);

    logic [TIMER_BITS-1:0] boot_load;
    logic [TIMER_BITS-1:0] align_load;
    logic [TIMER_BITS-1:0] stop_load;
    logic [TIMER_BITS-1:0] wait_dec;
    logic                  wait_done;
    logic [2:0]            held;

    // Tick counts are cut or zero-extended to the counter width
    assign boot_load  = TIMER_BITS'(cfg.boot_charge_ticks);
    assign align_load = TIMER_BITS'(cfg.align_ticks);
    assign stop_load  = TIMER_BITS'(cfg.stop_dwell_ticks);

    // Count down, holding at zero; wait ends when the stepped value is zero
    assign wait_dec  = (wait_cur == '0) ? '0 : wait_cur - TIMER_BITS'(1);
    assign wait_done = (wait_dec == '0);

    always_comb
    begin
        held = cur.held_command;
        if (in_word.command == CMD_START || in_word.command == CMD_MEASURE ||
            in_word.command == CMD_STOP || in_word.command == CMD_ACK)
        begin
            held = in_word.command;
        end

        nxt              = cur;
        nxt.held_command = held;
        wait_nxt         = wait_cur;
        res              = '0;

        if (in_word.fault_active || in_word.timing_overrun)
        begin
            nxt.phase       = PH_FNOW;
            nxt.pwm_enabled = 1'b0;
        end
        else if (in_word.fault_occurred)
        begin
            nxt.phase       = PH_FOVER;
            nxt.pwm_enabled = 1'b0;
        end
        else
        begin
            case (cur.phase)
                PH_IDLE:
                begin
                    if (held == CMD_START || held == CMD_MEASURE)
                    begin
                        if (!in_word.offsets_known)
                        begin
                            res.calib_start = 1'b1;
                            nxt.phase       = PH_CALIB;
                        end
                        else
                        begin
                            res.low_sides_on = 1'b1;
                            nxt.pwm_enabled  = 1'b1;
                            wait_nxt         = boot_load;
                            nxt.phase        = PH_BOOT;
                        end
                    end
                end
                PH_CALIB:
                begin
                    if (held == CMD_STOP)
                    begin
                        nxt.pwm_enabled = 1'b0;
                        wait_nxt        = stop_load;
                        nxt.phase       = PH_STOP;
                    end
                    else if (in_word.calib_done)
                    begin
                        if (held == CMD_MEASURE)
                        begin
                            nxt.held_command = CMD_NONE;
                            nxt.phase        = PH_IDLE;
                        end
                        else
                        begin
                            res.low_sides_on = 1'b1;
                            nxt.pwm_enabled  = 1'b1;
                            wait_nxt         = boot_load;
                            nxt.phase        = PH_BOOT;
                        end
                    end
                end
                PH_BOOT:
                begin
                    if (held == CMD_STOP)
                    begin
                        nxt.pwm_enabled = 1'b0;
                        wait_nxt        = stop_load;
                        nxt.phase       = PH_STOP;
                    end
                    else
                    begin
                        wait_nxt = wait_dec;
                        if (wait_done)
                        begin
                            res.sensor_reset = 1'b1;
                            nxt.pwm_enabled  = 1'b1;
                            if (in_word.sensor_aligned && in_word.sensor_online)
                            begin
                                res.run_entry = 1'b1;
                                nxt.phase     = PH_RUN;
                            end
                            else
                            begin
                                wait_nxt  = align_load;
                                nxt.phase = PH_ALIGN;
                            end
                        end
                    end
                end
                PH_ALIGN:
                begin
                    if (held == CMD_STOP)
                    begin
                        nxt.pwm_enabled = 1'b0;
                        wait_nxt        = stop_load;
                        nxt.phase       = PH_STOP;
                    end
                    else
                    begin
                        wait_nxt = wait_dec;
                        if (wait_done)
                        begin
                            if (in_word.capture_ok)
                            begin
                                res.run_entry = 1'b1;
                                nxt.phase     = PH_RUN;
                            end
                            else
                            begin
                                res.speed_fault = 1'b1;
                                nxt.pwm_enabled = 1'b0;
                                nxt.phase       = PH_FNOW;
                            end
                        end
                    end
                end
                PH_RUN:
                begin
                    if (held == CMD_STOP)
                    begin
                        nxt.pwm_enabled = 1'b0;
                        wait_nxt        = stop_load;
                        nxt.phase       = PH_STOP;
                    end
                    else if (!in_word.speed_ok)
                    begin
                        res.speed_fault = 1'b1;
                        nxt.pwm_enabled = 1'b0;
                        nxt.phase       = PH_FNOW;
                    end
                end
                PH_STOP:
                begin
                    wait_nxt = wait_dec;
                    if (wait_done)
                    begin
                        res.sensor_reset = 1'b1;
                        nxt.held_command = CMD_NONE;
                        nxt.phase        = PH_IDLE;
                    end
                end
                PH_FOVER:
                begin
                    if (held == CMD_ACK)
                    begin
                        nxt.held_command = CMD_NONE;
                        nxt.phase        = PH_IDLE;
                    end
                end
                default: // active fault phase steps to the latched one
                begin
                    nxt.phase = PH_FOVER;
                end
            endcase
        end

        res.phase         = nxt.phase;
        res.pwm_on        = nxt.pwm_enabled;
        res.align_current = (nxt.phase == PH_ALIGN);
    end

endmodule

`default_nettype wire

// ===== rtl/motor_drive_start_stop_sequencer_core.sv =====
// Top level of the motor drive start/stop sequencer.
// Depends on mdss_pkg, mdss_cfg and mdss_step.
//
// One input word per control tick, one result word per input word. The
// sequencer state (phase, held command, wait counter, PWM enable) updates at
// the edge where an input word is accepted, and the result for that word is
// loaded into the output register at the same edge, so a result appears in
// the cycle after its input. The block takes a new word every cycle unless
// the output stalls: in_ready is high whenever the output register is empty
// or is being drained this cycle, so throughput is one word per clock with no
// bubbles while out_ready is high. The only feedback path is the state
// registers through the step logic, a few muxes and one TIMER_BITS-wide
// decrement. Waits in bootcharge, align and stop are counted in accepted
// words, not clocks; a loaded count of 0 or 1 ends the wait on the first word
// of the phase. Config writes are registered and are meant to happen only
// while no word is in flight. Wider tick counts are cut to TIMER_BITS on load.
`default_nettype none

module motor_drive_start_stop_sequencer_core
    import mdss_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire in_word_t                   in_word,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output out_word_t                       out_word,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

    cfg_t                  cfg;
    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic [TIMER_BITS-1:0] wait_reg;
    logic [TIMER_BITS-1:0] wait_next;
    out_word_t             res_next;
    out_word_t             out_word_reg;
    logic                  out_valid_reg;
    logic                  in_fire;

    mdss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mdss_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .in_word  (in_word),
        .cfg      (cfg),
        .cur      (state_reg),
        .wait_cur (wait_reg),
        .nxt      (state_next),
        .wait_nxt (wait_next),
        .res      (res_next)
    );

    // Output register frees up when it is empty or drained this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_IDLE;
            state_reg.held_command <= CMD_NONE;
            state_reg.pwm_enabled  <= 1'b0;
            wait_reg               <= '0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
                wait_reg  <= wait_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_word_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Bridge is never enabled while idle, stopping or calibrating
    a_pwm_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_IDLE || state_reg.phase == PH_STOP ||
         state_reg.phase == PH_CALIB) |-> !state_reg.pwm_enabled)
        else $error("pwm enabled in a quiet phase");

    // Fault phases always report the bridge off
    a_fault_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_word_reg.phase == PH_FNOW ||
                           out_word_reg.phase == PH_FOVER)) |-> !out_word_reg.pwm_on)
        else $error("pwm on in a fault phase");

    // A run entry pulse lands in run with the bridge on
    a_run_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.run_entry) |->
            (out_word_reg.phase == PH_RUN && out_word_reg.pwm_on))
        else $error("run entry without run phase");

    // Result word leaves the register with the state it describes
    a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (out_word_reg.phase == state_reg.phase &&
                     out_word_reg.pwm_on == state_reg.pwm_enabled))
        else $error("result word out of step with state");

endmodule

`default_nettype wire

// ===== dv/mdss_sequence_checker.sv =====
// Scoreboard for the motor drive start/stop sequencer: mirrors the timer registers
// and sequencer state, predicts one status word per accepted command word and
// compares it field by field with the block's output. Depends on mdss_pkg.
module mdss_sequence_checker
    import mdss_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  in_word_t                   in_word,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  out_word_t                  out_word,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    output int                         mismatch_count,
    output int                         status_checked,
    output int                         status_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 30;

    // Mirrored timer registers
    logic [CFG_WIDTH-1:0]  boot_ticks;
    logic [CFG_WIDTH-1:0]  align_ticks;
    logic [CFG_WIDTH-1:0]  dwell_ticks;

    // Mirrored sequencer state
    logic [2:0]            phase_q;
    logic [2:0]            held_q;
    logic [TIMER_BITS-1:0] wait_q;
    logic                  pwm_q;

    out_word_t             pending_status[$];
    out_word_t             want;

    function automatic void note_mismatch(string what, logic [2:0] exp_v, logic [2:0] got_v);
        if (exp_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                         $time, what, exp_v, got_v);
        end
    endfunction

    function automatic void enter_stop();
        pwm_q   = 1'b0;
        wait_q  = TIMER_BITS'(dwell_ticks);
        phase_q = PH_STOP;
    endfunction

    function automatic void enter_boot();
        pwm_q   = 1'b1;
        wait_q  = TIMER_BITS'(boot_ticks);
        phase_q = PH_BOOT;
    endfunction

    // Decrement holding at zero; true once the wait is over.
    function automatic logic count_down();
        if (wait_q != '0)
            wait_q = wait_q - TIMER_BITS'(1);
        return wait_q == '0;
    endfunction

    function automatic out_word_t advance_phase(in_word_t w);
        out_word_t r;
        r = '0;
        if (w.command >= CMD_START && w.command <= CMD_ACK)
            held_q = w.command;

        if (w.fault_active || w.timing_overrun) begin
            phase_q = PH_FNOW;
            pwm_q   = 1'b0;
        end
        else if (w.fault_occurred) begin
            phase_q = PH_FOVER;
            pwm_q   = 1'b0;
        end
        else begin
            case (phase_q)
                PH_IDLE:
                    if (held_q == CMD_START || held_q == CMD_MEASURE) begin
                        if (!w.offsets_known) begin
                            r.calib_start = 1'b1;
                            phase_q       = PH_CALIB;
                        end
                        else begin
                            r.low_sides_on = 1'b1;
                            enter_boot();
                        end
                    end
                PH_CALIB:
                    if (held_q == CMD_STOP)
                        enter_stop();
                    else if (w.calib_done) begin
                        if (held_q == CMD_MEASURE) begin
                            held_q  = CMD_NONE;
                            phase_q = PH_IDLE;
                        end
                        else begin
                            r.low_sides_on = 1'b1;
                            enter_boot();
                        end
                    end
                PH_BOOT:
                    if (held_q == CMD_STOP)
                        enter_stop();
                    else if (count_down()) begin
                        r.sensor_reset = 1'b1;
                        pwm_q          = 1'b1;
                        if (w.sensor_aligned && w.sensor_online) begin
                            r.run_entry = 1'b1;
                            phase_q     = PH_RUN;
                        end
                        else begin
                            wait_q  = TIMER_BITS'(align_ticks);
                            phase_q = PH_ALIGN;
                        end
                    end
                PH_ALIGN:
                    if (held_q == CMD_STOP)
                        enter_stop();
                    else if (count_down()) begin
                        if (w.capture_ok) begin
                            r.run_entry = 1'b1;
                            phase_q     = PH_RUN;
                        end
                        else begin
                            r.speed_fault = 1'b1;
                            pwm_q         = 1'b0;
                            phase_q       = PH_FNOW;
                        end
                    end
                PH_RUN:
                    if (held_q == CMD_STOP)
                        enter_stop();
                    else if (!w.speed_ok) begin
                        r.speed_fault = 1'b1;
                        pwm_q         = 1'b0;
                        phase_q       = PH_FNOW;
                    end
                PH_STOP:
                    if (count_down()) begin
                        r.sensor_reset = 1'b1;
                        held_q         = CMD_NONE;
                        phase_q        = PH_IDLE;
                    end
                PH_FOVER:
                    if (held_q == CMD_ACK) begin
                        held_q  = CMD_NONE;
                        phase_q = PH_IDLE;
                    end
                default:
                    phase_q = PH_FOVER;
            endcase
        end

        r.phase         = phase_q;
        r.pwm_on        = pwm_q;
        r.align_current = (phase_q == PH_ALIGN);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            boot_ticks  = BOOT_CHARGE_RESET;
            align_ticks = ALIGN_RESET;
            dwell_ticks = STOP_DWELL_RESET;
            phase_q     = PH_IDLE;
            held_q      = CMD_NONE;
            wait_q      = '0;
            pwm_q       = 1'b0;
            pending_status.delete();
            status_pending <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_BOOT_CHARGE: boot_ticks  = cfg_data;
                    REG_ALIGN:       align_ticks = cfg_data;
                    REG_STOP_DWELL:  dwell_ticks = cfg_data;
                    default: ;
                endcase
            end
            // Retire before predicting: a result leaving now belongs to an older word.
            if (out_valid && out_ready) begin
                if (pending_status.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t ns: unexpected status word: expected nothing, actual %h",
                                 $time, out_word);
                end
                else begin
                    want = pending_status.pop_front();
                    status_checked++;
                    note_mismatch("phase", want.phase, out_word.phase);
                    note_mismatch("pwm_on", 3'(want.pwm_on), 3'(out_word.pwm_on));
                    note_mismatch("calib_start", 3'(want.calib_start),
                                  3'(out_word.calib_start));
                    note_mismatch("low_sides_on", 3'(want.low_sides_on),
                                  3'(out_word.low_sides_on));
                    note_mismatch("align_current", 3'(want.align_current),
                                  3'(out_word.align_current));
                    note_mismatch("run_entry", 3'(want.run_entry), 3'(out_word.run_entry));
                    note_mismatch("speed_fault", 3'(want.speed_fault),
                                  3'(out_word.speed_fault));
                    note_mismatch("sensor_reset", 3'(want.sensor_reset),
                                  3'(out_word.sensor_reset));
                end
            end
            if (in_valid && in_ready)
                pending_status.push_back(advance_phase(in_word));
            status_pending <= pending_status.size();
        end
    end

endmodule

// ===== dv/motor_drive_start_stop_sequencer_core_tb.sv =====
// Testbench top for the motor drive start/stop sequencer: clock, reset, command
// word stimulus, timer register writes, output back-pressure and the verdict.
// Depends on mdss_pkg, the sequencer RTL and mdss_sequence_checker.
module motor_drive_start_stop_sequencer_core_tb;
    import mdss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CLK_PERIOD     = 8;
    localparam int   TIMER_BITS     = 16;
    localparam int   IN_BITS        = $bits(in_word_t);
    // No handshake for this long means the block has hung. A correct run never
    // goes longer without one than the longest sender gap plus the longest receiver stall.
    localparam int   WATCHDOG_LIMIT = 1000;
    // Not a command: the held command must survive it.
    localparam logic [2:0] CMD_UNDEFINED = 3'd5;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    in_word_t                   in_word   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    out_word_t                  out_word;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_data  = '0;

    int mismatch_count;
    int status_checked;
    int status_pending;

    int words_sent    = 0;
    int settings_used = 0;
    int idle_cycles   = 0;
    bit quiet_tail    = 1'b0;   // last stretch: both sides run flat out

    always #(CLK_PERIOD / 2) clk = ~clk;

    motor_drive_start_stop_sequencer_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mdss_sequence_checker #(
        .TIMER_BITS (TIMER_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_word       (out_word),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .status_checked (status_checked),
        .status_pending (status_pending)
    );

    // Healthy status word: no faults, caller picks the sequencing flags.
    function automatic in_word_t plain_word(logic [2:0] cmd, logic offs, logic cal,
                                            logic algn, logic onl, logic cap, logic spd);
        in_word_t w;
        w                = '0;
        w.command        = cmd;
        w.offsets_known  = offs;
        w.calib_done     = cal;
        w.sensor_aligned = algn;
        w.sensor_online  = onl;
        w.capture_ok     = cap;
        w.speed_ok       = spd;
        return w;
    endfunction

    // Present one word and hold it until the block takes it. Called at a
    // rising edge; returns at the edge where the word was accepted.
    task automatic send_word(input in_word_t w);
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // Stop sending and wait until every predicted status word has come back.
    // The first edge lets the checker count a word accepted at this very edge.
    task automatic drain_status();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (status_pending != 0);
    endtask

    // Write all three timer registers back to back; only called when drained.
    task automatic load_timers(input logic [CFG_WIDTH-1:0] boot,
                               input logic [CFG_WIDTH-1:0] align,
                               input logic [CFG_WIDTH-1:0] dwell);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BOOT_CHARGE;
        cfg_data  <= boot;
        @(posedge clk);
        cfg_index <= REG_ALIGN;
        cfg_data  <= align;
        @(posedge clk);
        cfg_index <= REG_STOP_DWELL;
        cfg_data  <= dwell;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One timer setting followed by a burst of random command words.
    // Most words look like a real controller: rare faults, mostly "keep"
    // commands, sensor mostly healthy, so the sequence reaches calib, boot,
    // align, run and stop. About one word in eight is raw noise over all bits.
    task automatic run_setting(input logic [CFG_WIDTH-1:0] boot,
                               input logic [CFG_WIDTH-1:0] align,
                               input logic [CFG_WIDTH-1:0] dwell,
                               input int count);
        in_word_t           w;
        logic [IN_BITS-1:0] raw;
        int                 pick;
        load_timers(boot, align, dwell);
        settings_used++;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 12) begin
                raw = IN_BITS'($urandom);
                w   = in_word_t'(raw);
            end
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    w.command = CMD_NONE;
                else if (pick < 78)
                    w.command = CMD_START;
                else if (pick < 84)
                    w.command = CMD_MEASURE;
                else if (pick < 90)
                    w.command = CMD_STOP;
                else if (pick < 97)
                    w.command = CMD_ACK;
                else
                    w.command = 3'($urandom_range(CMD_UNDEFINED, 7));
                w.fault_active   = ($urandom_range(0, 59) == 0);
                w.timing_overrun = ($urandom_range(0, 59) == 0);
                w.fault_occurred = ($urandom_range(0, 29) == 0);
                w.offsets_known  = 1'($urandom_range(0, 1));
                w.calib_done     = ($urandom_range(0, 3) == 0);
                w.sensor_aligned = 1'($urandom_range(0, 1));
                w.sensor_online  = ($urandom_range(0, 4) != 0);
                w.capture_ok     = ($urandom_range(0, 4) != 0);
                w.speed_ok       = ($urandom_range(0, 29) != 0);
            end
            // Sender gaps, and now and then a full drain mid-setting so the
            // block sees an empty pipe in the middle of a sequence.
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 299) == 0)
                drain_status();
            send_word(w);
        end
        drain_status();
    endtask

    // Receiver back-pressure: random ready runs, now and then broken by a random stall;
    // no stalls once the quiet tail starts.
    initial
    begin
        wait (rst_n);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    // Watchdog: any cycle with a handshake on either side counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: watchdog: no handshake for %0d cycles, %0d words outstanding",
                         $time, WATCHDOG_LIMIT, status_pending);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        in_word_t w;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with short timers: boot wait of one ends on the first
        // word of the phase, align needs three words.
        load_timers(16'd1, 16'd3, 16'd2);
        settings_used++;
        // start without offsets: calib, hold, then calib done into boot
        send_word(plain_word(CMD_START, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_NONE,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_NONE,  1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
        // boot ends, sensor not aligned: sensor reset pulse, into align
        send_word(plain_word(CMD_NONE,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_NONE,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_NONE,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        // align times out with a failed capture: speed fault, active fault phase
        send_word(plain_word(CMD_NONE,  1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        // active fault steps to the latched fault; stop there is ignored; ack clears
        send_word(plain_word(CMD_NONE,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_STOP,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_ACK,   1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        // measure with offsets known behaves like start; aligned sensor skips align
        send_word(plain_word(CMD_MEASURE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_NONE,  1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
        // undefined command keeps the held command; then speed check fails in run
        send_word(plain_word(CMD_UNDEFINED, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_NONE,  1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        // latched fault flag alone forces the latched fault phase
        w = plain_word(CMD_NONE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        w.fault_occurred = 1'b1;
        send_word(w);
        send_word(plain_word(CMD_ACK,   1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        // measure without offsets: calibrate, then straight back to idle
        send_word(plain_word(CMD_MEASURE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_NONE,  1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
        // stop aborts boot; start during the dwell is ignored; dwell ends in idle
        send_word(plain_word(CMD_START, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_STOP,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_START, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_word(plain_word(CMD_NONE,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        // acknowledge outside the latched fault phase only changes the held command
        send_word(plain_word(CMD_ACK,   1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        // all-ones word (every fault at once), overrun alone, all-zeros word
        send_word('1);
        w = '0;
        w.timing_overrun = 1'b1;
        send_word(w);
        send_word('0);
        drain_status();

        // Random part over a spread of timer settings, extremes first.
        run_setting(16'd0, 16'd0, 16'd0, 150);
        run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 60);
        repeat (8)
            run_setting(CFG_WIDTH'($urandom_range(0, 12)), CFG_WIDTH'($urandom_range(0, 12)),
                        CFG_WIDTH'($urandom_range(0, 12)), 150);
        run_setting(CFG_WIDTH'($urandom_range(1, 40)), CFG_WIDTH'($urandom_range(1, 40)),
                    CFG_WIDTH'($urandom_range(1, 40)), 100);
        quiet_tail = 1'b1;
        run_setting(CFG_WIDTH'($urandom_range(0, 12)), CFG_WIDTH'($urandom_range(0, 12)),
                    CFG_WIDTH'($urandom_range(0, 12)), 200);

        // Everything is back; give a stray extra word time to show up.
        repeat (8) @(posedge clk);

        $display("Sent %0d command words under %0d timer settings; %0d status words compared.",
                 words_sent, settings_used, status_checked);
        $display("Timers went from zero to full scale; %0d field mismatches seen.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
